// File: hw/rtl/esc_pkg.sv
// Package for the environmental sensor compensation block.
// Holds register indexes and shared 32-bit arithmetic helpers. No dependencies.
package esc_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;
    typedef enum logic [CfgIdxW-1:0] {
        REG_TEMP_CAL    = 3'd0,
        REG_PRESS_CAL_A = 3'd1,
        REG_PRESS_CAL_B = 3'd2,
        REG_PRESS_CAL_C = 3'd3,
        REG_HUM_CAL     = 3'd4
    } cfg_idx_t;

    // Stages of the quotient unit: one quotient bit each.
    localparam int DivBits = 32;

    // Tag through the quotient unit: temperature, fine temperature,
    // humidity product, large-dividend flag, zero-divisor flag.
    localparam int DivTagW = 32 + 32 + 32 + 1 + 1;

    typedef logic [31:0] w32_t;

    // Wrapping 32-bit multiply.
    function automatic w32_t mul32(input w32_t x, input w32_t y);
        begin
            return x * y;
        end
    endfunction

    // Arithmetic right shift by a constant.
    function automatic w32_t asr(input w32_t x, input int s);
        begin
            return w32_t'($signed(x) >>> s);
        end
    endfunction

endpackage

// File: hw/rtl/env_sensor_compensation.sv
// Top level of the environmental sensor compensation pipeline.
// Depends on esc_pkg and esc_div.
//
// channel   | handshake             | words
// cfg       | cfg_valid/cfg_ready   | cfg_index, cfg_data
// sample    | start, busy           | raw_temp, raw_press, raw_hum
// result    | done strobe           | temperature, fine_temp, pressure, humidity,
//           |                       | press_div_zero
//
// One sample a cycle; the path runs through six stages before the quotient
// unit, its operand register and 32 quotient stages, and four stages after it.
// busy is always low; cfg_ready is always high. Reset clears calibration to 0
// and empties the pipeline. The receiver cannot stall: done lasts one cycle.
module env_sensor_compensation (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [esc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [esc_pkg::CfgDataW-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [19:0]           raw_temp,
    input  logic [19:0]           raw_press,
    input  logic [15:0]           raw_hum,
    output logic                  done,
    output logic signed [31:0]    temperature,
    output logic signed [31:0]    fine_temp,
    output logic [31:0]           pressure,
    output logic [16:0]           humidity,
    output logic                  press_div_zero
);
    import esc_pkg::*;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_a_reg, press_b_reg, hum_cal_reg;
    logic [15:0] press_c_reg;

    assign cfg_ready = 1'b1;
    assign busy = 1'b0;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            press_c_reg  <= '0;
            hum_cal_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEMP_CAL:    temp_cal_reg <= cfg_data[47:0];
                REG_PRESS_CAL_A: press_a_reg  <= cfg_data;
                REG_PRESS_CAL_B: press_b_reg  <= cfg_data;
                REG_PRESS_CAL_C: press_c_reg  <= cfg_data[15:0];
                REG_HUM_CAL:     hum_cal_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Coefficient fields.
    w32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, temp_cal_reg[15:0]};
    assign t2 = {{16{temp_cal_reg[31]}}, temp_cal_reg[31:16]};
    assign t3 = {{16{temp_cal_reg[47]}}, temp_cal_reg[47:32]};
    assign p1 = {16'd0, press_a_reg[15:0]};
    assign p2 = {{16{press_a_reg[31]}}, press_a_reg[31:16]};
    assign p3 = {{16{press_a_reg[47]}}, press_a_reg[47:32]};
    assign p4 = {{16{press_a_reg[63]}}, press_a_reg[63:48]};
    assign p5 = {{16{press_b_reg[15]}}, press_b_reg[15:0]};
    assign p6 = {{16{press_b_reg[31]}}, press_b_reg[31:16]};
    assign p7 = {{16{press_b_reg[47]}}, press_b_reg[47:32]};
    assign p8 = {{16{press_b_reg[63]}}, press_b_reg[63:48]};
    assign p9 = {{16{press_c_reg[15]}}, press_c_reg};
    assign h1 = {24'd0, hum_cal_reg[7:0]};
    assign h2 = {{16{hum_cal_reg[23]}}, hum_cal_reg[23:8]};
    assign h3 = {24'd0, hum_cal_reg[31:24]};
    assign h4 = {{20{hum_cal_reg[43]}}, hum_cal_reg[43:32]};
    assign h5 = {{20{hum_cal_reg[55]}}, hum_cal_reg[55:44]};
    assign h6 = {{24{hum_cal_reg[63]}}, hum_cal_reg[63:56]};

    // Stage 1: first temperature products.
    logic [5:0] v_reg;
    logic [19:0] s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg, s5_adcp_reg;
    logic [15:0] s1_adch_reg, s2_adch_reg;
    w32_t s1_a_reg, s1_d2_reg;
    always_ff @(posedge clk)
    begin
        s1_adcp_reg <= raw_press;
        s1_adch_reg <= raw_hum;
        s1_a_reg <= mul32(({15'd0, raw_temp[19:3]} - (t1 << 1)), t2);
        s1_d2_reg <= mul32({16'd0, raw_temp[19:4]} - t1, {16'd0, raw_temp[19:4]} - t1);
    end

    // Stage 2: fine temperature.
    w32_t s2_tf_reg;
    always_ff @(posedge clk)
    begin
        s2_adcp_reg <= s1_adcp_reg;
        s2_adch_reg <= s1_adch_reg;
        s2_tf_reg <= asr(s1_a_reg, 11) + asr(mul32(asr(s1_d2_reg, 12), t3), 14);
    end

    // Stage 3: temperature, pressure offsets, humidity first terms.
    w32_t s3_tf_reg, s3_temp_reg, s3_pa_reg, s3_q_reg, s3_hx_reg;
    w32_t s3_h6_reg, s3_h3_reg;
    w32_t pa3, ha3;
    assign pa3 = asr(s2_tf_reg, 1) - 32'd64000;
    assign ha3 = s2_tf_reg - 32'd76800;
    always_ff @(posedge clk)
    begin
        s3_adcp_reg <= s2_adcp_reg;
        s3_tf_reg <= s2_tf_reg;
        s3_temp_reg <= asr(mul32(s2_tf_reg, 32'd5) + 32'd128, 8);
        s3_pa_reg <= pa3;
        s3_q_reg <= mul32(asr(pa3, 2), asr(pa3, 2));
        s3_hx_reg <= asr(({16'd0, s2_adch_reg} << 14) - (h4 << 20) - mul32(h5, ha3)
                         + 32'd16384, 15);
        s3_h6_reg <= asr(mul32(ha3, h6), 10);
        s3_h3_reg <= asr(mul32(ha3, h3), 11) + 32'd32768;
    end

    // Stage 4: pressure partials, humidity product.
    w32_t s4_tf_reg, s4_temp_reg, s4_b_reg, s4_a_reg, s4_hx_reg, s4_hd_reg;
    always_ff @(posedge clk)
    begin
        s4_adcp_reg <= s3_adcp_reg;
        s4_tf_reg <= s3_tf_reg;
        s4_temp_reg <= s3_temp_reg;
        s4_b_reg <= asr(mul32(asr(s3_q_reg, 11), p6) + (mul32(s3_pa_reg, p5) << 1), 2)
                    + (p4 << 16);
        s4_a_reg <= asr(asr(mul32(p3, asr(s3_q_reg, 13)), 3)
                    + asr(mul32(p2, s3_pa_reg), 1), 18);
        s4_hx_reg <= s3_hx_reg;
        s4_hd_reg <= mul32(s3_h6_reg, s3_h3_reg);
    end

    // Stage 5: divisor and humidity scale.
    w32_t s5_tf_reg, s5_temp_reg, s5_b_reg, s5_div_reg, s5_hx_reg, s5_hd_reg;
    always_ff @(posedge clk)
    begin
        s5_adcp_reg <= s4_adcp_reg;
        s5_tf_reg <= s4_tf_reg;
        s5_temp_reg <= s4_temp_reg;
        s5_b_reg <= s4_b_reg;
        s5_div_reg <= asr(mul32(32'd32768 + s4_a_reg, p1), 15);
        s5_hx_reg <= s4_hx_reg;
        s5_hd_reg <= asr(mul32(asr(s4_hd_reg, 10) + 32'd2097152, h2) + 32'd8192, 14);
    end

    // Stage 6: dividend, humidity product.
    w32_t s6_tf_reg, s6_temp_reg, s6_div_reg, s6_p_reg, s6_ha_reg;
    always_ff @(posedge clk)
    begin
        s6_tf_reg <= s5_tf_reg;
        s6_temp_reg <= s5_temp_reg;
        s6_div_reg <= s5_div_reg;
        s6_p_reg <= mul32((32'd1048576 - {12'd0, s5_adcp_reg}) - asr(s5_b_reg, 12),
                          32'd3125);
        s6_ha_reg <= mul32(s5_hx_reg, s5_hd_reg);
    end

    // Quotient unit; the low half of the two forms goes in by dividend choice.
    // The humidity product rides the tag and is finished after the divider.
    logic big6, dz6;
    w32_t dvd6;
    assign big6 = s6_p_reg[31];
    assign dz6  = (s6_div_reg == '0);
    assign dvd6 = big6 ? s6_p_reg : (s6_p_reg << 1);

    logic dv_valid;
    w32_t dv_q;
    logic [DivTagW-1:0] dv_tag;
    esc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[5]),
        .dividend  (dvd6),
        .divisor   (dz6 ? 32'd1 : s6_div_reg),
        .in_tag    ({s6_temp_reg, s6_tf_reg, s6_ha_reg, big6, dz6}),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .out_tag   (dv_tag)
    );

    // Post stage A: quotient fixup, humidity square.
    logic [3:0] pv_reg;
    w32_t pa_p_reg, pa_hsq_reg;
    w32_t hq_a;
    logic [DivTagW-1:0] pa_tag_reg, pb_tag_reg, pc_tag_reg, pd_tag_reg;
    assign hq_a = asr(dv_tag[33:2], 15);
    always_ff @(posedge clk)
    begin
        pa_tag_reg <= dv_tag;
        pa_p_reg <= dv_tag[1] ? (dv_q << 1) : dv_q;
        pa_hsq_reg <= asr(mul32(hq_a, hq_a), 7);
    end

    // Humidity finish and clamp.
    w32_t hv_b;
    logic [16:0] hum_b;
    assign hv_b = pa_tag_reg[33:2] - asr(mul32(pa_hsq_reg, h1), 4);
    always_comb
    begin
        if (hv_b[31])
        begin
            hum_b = '0;
        end
        else if (hv_b > 32'd419430400)
        begin
            hum_b = 17'd102400;
        end
        else
        begin
            hum_b = hv_b[28:12];
        end
    end

    // Post stage B: correction products, humidity.
    w32_t pb_p_reg, pb_sq_reg, pb_b_reg;
    logic [16:0] pb_hum_reg, pc_hum_reg, pd_hum_reg;
    always_ff @(posedge clk)
    begin
        pb_tag_reg <= pa_tag_reg;
        pb_p_reg <= pa_p_reg;
        pb_sq_reg <= mul32({3'd0, pa_p_reg[31:3]}, {3'd0, pa_p_reg[31:3]}) >> 13;
        pb_b_reg <= asr(mul32({2'd0, pa_p_reg[31:2]}, p8), 13);
        pb_hum_reg <= hum_b;
    end

    // Post stage C: P9 product.
    w32_t pc_p_reg, pc_a_reg, pc_b_reg;
    always_ff @(posedge clk)
    begin
        pc_tag_reg <= pb_tag_reg;
        pc_p_reg <= pb_p_reg;
        pc_a_reg <= asr(mul32(p9, pb_sq_reg), 12);
        pc_b_reg <= pb_b_reg;
        pc_hum_reg <= pb_hum_reg;
    end

    // Post stage D: final pressure.
    w32_t pd_p_reg;
    always_ff @(posedge clk)
    begin
        pd_tag_reg <= pc_tag_reg;
        pd_p_reg <= pc_tag_reg[0] ? 32'd0
                  : pc_p_reg + asr(pc_a_reg + pc_b_reg + p7, 4);
        pd_hum_reg <= pc_hum_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            pv_reg <= '0;
        end
        else
        begin
            v_reg  <= {v_reg[4:0], start};
            pv_reg <= {pv_reg[2:0], dv_valid};
        end
    end

    assign done           = pv_reg[3];
    assign temperature    = pd_tag_reg[DivTagW-1 -: 32];
    assign fine_temp      = pd_tag_reg[DivTagW-33 -: 32];
    assign humidity       = pd_hum_reg;
    assign pressure       = pd_p_reg;
    assign press_div_zero = pd_tag_reg[0];

    // A zero divisor always yields zero pressure.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && press_div_zero |-> pressure == '0)
        else $error("pressure not zero on zero divisor");
    // Humidity stays in range.
    a_hum_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> humidity <= 17'd102400)
        else $error("humidity out of range");
    // Divider output feeds the post stages in the next cycle.
    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid |=> pv_reg[0])
        else $error("divider word lost");

endmodule

// File: hw/rtl/esc_div.sv
// Pipelined restoring divider, 32-bit unsigned quotient, one bit per stage.
// Depends on esc_pkg. Carries a tag word alongside the operands.
module esc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [31:0]                 dividend,
    input  logic [31:0]                 divisor,
    input  logic [esc_pkg::DivTagW-1:0] in_tag,
    output logic                        out_valid,
    output logic [31:0]                 quotient,
    output logic [esc_pkg::DivTagW-1:0] out_tag
);
    import esc_pkg::*;

    logic [DivBits:0]      v_reg;
    logic [31:0]           rem_reg [DivBits+1];
    logic [31:0]           quo_reg [DivBits+1];
    logic [31:0]           dvs_reg [DivBits+1];
    logic [DivTagW-1:0]    tag_reg [DivBits+1];

    // Stage 0 takes the operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DivBits-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        quo_reg[0] <= dividend;
        dvs_reg[0] <= divisor;
        tag_reg[0] <= in_tag;
    end

    // One quotient bit a stage; dividend bits shift out the top of quo.
    for (genvar i = 0; i < DivBits; i++)
    begin : g_st
        logic [32:0] trial;
        logic [32:0] diff;
        assign trial = {rem_reg[i], quo_reg[i][31]};
        assign diff  = trial - {1'b0, dvs_reg[i]};
        always_ff @(posedge clk)
        begin
            if (!diff[32])
            begin
                rem_reg[i+1] <= diff[31:0];
            end
            else
            begin
                rem_reg[i+1] <= trial[31:0];
            end
            quo_reg[i+1] <= {quo_reg[i][30:0], ~diff[32]};
            dvs_reg[i+1] <= dvs_reg[i];
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_valid = v_reg[DivBits];
    assign quotient  = quo_reg[DivBits];
    assign out_tag   = tag_reg[DivBits];

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for env_sensor_compensation: sample and calibration traffic,
// with a built-in predictor. Depends on esc_pkg and the block's RTL.
module tb_top;
    import esc_pkg::*;

    // Indexes past the register list; writes there must be dropped
    localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 60;   // pipeline latency plus margin

    // Typical factory calibration set
    localparam logic [47:0] TEMP_CAL_TYP = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] PRESS_A_TYP  =
        {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] PRESS_B_TYP  =
        {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] PRESS_C_TYP  = 16'd6000;
    localparam logic [63:0] HUM_CAL_TYP  =
        {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } sample_t;

    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] fine_temp;
        logic [31:0] pressure;
        logic [16:0] humidity;
        logic        press_div_zero;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [19:0] raw_temp = '0;
    logic [19:0] raw_press = '0;
    logic [15:0] raw_hum = '0;
    logic        done;
    logic signed [31:0] temperature;
    logic signed [31:0] fine_temp;
    logic [31:0] pressure;
    logic [16:0] humidity;
    logic        press_div_zero;

    // Calibration as the block should hold it
    logic [47:0] temp_cal_q = '0;
    logic [63:0] press_a_q = '0;
    logic [63:0] press_b_q = '0;
    logic [15:0] press_c_q = '0;
    logic [63:0] hum_cal_q = '0;

    sample_t  pending_samples[$];
    reading_t expected_readings[$];
    int       mismatch_count = 0;
    bit       hold_samples = 1'b0;
    bit       idle_enable = 1'b1;

    env_sensor_compensation uut (.*);

    always #4 clk = ~clk;

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] sra(input logic [31:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Integer compensation of one sample triple with current calibration
    function automatic reading_t compensate(input sample_t s);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] adc_t, adc_p, adc_h, a, b, d, p, q, tf;
        reading_t r;
        t1 = {16'd0, temp_cal_q[15:0]};
        t2 = sext16(temp_cal_q[31:16]);
        t3 = sext16(temp_cal_q[47:32]);
        p1 = {16'd0, press_a_q[15:0]};
        p2 = sext16(press_a_q[31:16]);
        p3 = sext16(press_a_q[47:32]);
        p4 = sext16(press_a_q[63:48]);
        p5 = sext16(press_b_q[15:0]);
        p6 = sext16(press_b_q[31:16]);
        p7 = sext16(press_b_q[47:32]);
        p8 = sext16(press_b_q[63:48]);
        p9 = sext16(press_c_q);
        h1 = {24'd0, hum_cal_q[7:0]};
        h2 = sext16(hum_cal_q[23:8]);
        h3 = {24'd0, hum_cal_q[31:24]};
        h4 = {{20{hum_cal_q[43]}}, hum_cal_q[43:32]};
        h5 = {{20{hum_cal_q[55]}}, hum_cal_q[55:44]};
        h6 = {{24{hum_cal_q[63]}}, hum_cal_q[63:56]};
        adc_t = {12'd0, s.raw_temp};
        adc_p = {12'd0, s.raw_press};
        adc_h = {16'd0, s.raw_hum};

        // temperature
        a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d = (adc_t >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        tf = a + b;
        r.fine_temp = tf;
        r.temperature = sra(tf * 32'd5 + 32'd128, 8);

        // pressure
        a = sra(tf, 1) - 32'd64000;
        q = sra(a, 2) * sra(a, 2);
        b = sra(q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(q, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        r.press_div_zero = (a == 32'd0);
        if (r.press_div_zero)
            p = 32'd0;
        else
        begin
            p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
            if (p < 32'h80000000)
                p = (p << 1) / a;
            else
                p = (p / a) * 32'd2;
            a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = sra((p >> 2) * p8, 13);
            p = p + sra(a + b + p7, 4);
        end
        r.pressure = p;

        // humidity, clamped before the final shift
        a = tf - 32'd76800;
        b = sra(((adc_h << 14) - (h4 << 20) - (h5 * a)) + 32'd16384, 15);
        d = sra(a * h6, 10) * (sra(a * h3, 11) + 32'd32768);
        d = sra((sra(d, 10) + 32'd2097152) * h2 + 32'd8192, 14);
        a = b * d;
        q = sra(a, 15);
        a = a - sra(sra(q * q, 7) * h1, 4);
        if (a[31])
            a = 32'd0;
        if (a > 32'd419430400)
            a = 32'd419430400;
        a = a >> 12;
        r.humidity = a[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Sample driver: launches queued words, idles at random
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            if (start)
                expected_readings.push_back(compensate({raw_temp, raw_press, raw_hum}));
            if (!hold_samples && pending_samples.size() > 0 &&
                !(idle_enable && $urandom_range(99) < 19))
            begin
                sample_t s;
                s = pending_samples.pop_front();
                start     <= 1'b1;
                raw_temp  <= s.raw_temp;
                raw_press <= s.raw_press;
                raw_hum   <= s.raw_hum;
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                reading_t e;
                e = expected_readings.pop_front();
                if (temperature !== e.temperature)
                    report_mismatch($sformatf("temperature %0d, want %0d",
                        temperature, $signed(e.temperature)));
                if (fine_temp !== e.fine_temp)
                    report_mismatch($sformatf("fine_temp %0d, want %0d",
                        fine_temp, $signed(e.fine_temp)));
                if (pressure !== e.pressure)
                    report_mismatch($sformatf("pressure %0d, want %0d",
                        pressure, e.pressure));
                if (humidity !== e.humidity)
                    report_mismatch($sformatf("humidity %0d, want %0d",
                        humidity, e.humidity));
                if (press_div_zero !== e.press_div_zero)
                    report_mismatch($sformatf("press_div_zero %0b, want %0b",
                        press_div_zero, e.press_div_zero));
            end
        end
    end

    task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TEMP_CAL:    temp_cal_q = value[47:0];
            REG_PRESS_CAL_A: press_a_q = value;
            REG_PRESS_CAL_B: press_b_q = value;
            REG_PRESS_CAL_C: press_c_q = value[15:0];
            REG_HUM_CAL:     hum_cal_q = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [63:0] tc, input logic [63:0] pa,
                             input logic [63:0] pb, input logic [63:0] pc,
                             input logic [63:0] hc);
        write_cal(REG_TEMP_CAL, tc);
        write_cal(REG_PRESS_CAL_A, pa);
        write_cal(REG_PRESS_CAL_B, pb);
        write_cal(REG_PRESS_CAL_C, pc);
        write_cal(REG_HUM_CAL, hc);
    endtask

    // Wait until every queued word is out and its result is back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_samples.size() > 0 || start || expected_readings.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [19:0] t, input logic [19:0] p,
                                input logic [15:0] h);
        sample_t s;
        s.raw_temp = t;
        s.raw_press = p;
        s.raw_hum = h;
        pending_samples.push_back(s);
    endtask

    // Mostly sensor-like raw values, some anywhere in the field range
    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 60)
                queue_sample(20'($urandom_range(600000, 400000)),
                             20'($urandom_range(500000, 250000)),
                             16'($urandom_range(45000, 15000)));
            else
                queue_sample(20'($urandom), 20'($urandom), 16'($urandom));
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: every word hits the zero divisor
        queue_sample(20'd0, 20'd0, 16'd0);
        queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        queue_sample(20'hAAAAA, 20'h55555, 16'hA5A5);
        queue_sample(20'd519888, 20'd415148, 16'd30000);
        drain();

        // Typical set; upper bits of narrow registers and spare indexes ignored
        write_all({16'hDEAD, TEMP_CAL_TYP}, PRESS_A_TYP, PRESS_B_TYP,
                  {48'hFFFF_1234_5678, PRESS_C_TYP}, HUM_CAL_TYP);
        write_cal(CFG_IDX_SPARE_LO, rand64());
        write_cal(CFG_IDX_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_sample(20'd519888, 20'd415148, 16'd30000);
        queue_sample(20'd0, 20'd0, 16'd0);
        queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        queue_sample(20'd519888, 20'd0, 16'd0);
        queue_sample(20'd519888, 20'hFFFFF, 16'hFFFF);
        queue_sample(20'd0, 20'd415148, 16'd65535);
        queue_sample(20'hFFFFF, 20'd415148, 16'd0);
        queue_sample(20'd400000, 20'd300000, 16'd50000);
        queue_sample(20'd600000, 20'd500000, 16'd10000);
        drain();

        // Extremes of calibration
        write_all('1, '1, '1, '1, '1);
        queue_sample(20'd0, 20'd0, 16'd0);
        queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        queue_sample(20'd519888, 20'd415148, 16'd30000);
        drain();
        write_all(64'h8000_7FFF_FFFF, 64'h8000_7FFF_8000_FFFF,
                  64'h7FFF_8000_7FFF_8000, 64'h8000, 64'h80_7FF_800_FF_7FFF_FF);
        queue_sample(20'd0, 20'd0, 16'd0);
        queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        queue_sample(20'd519888, 20'd415148, 16'd30000);
        drain();

        // Random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: write_all(64'(TEMP_CAL_TYP) ^ 64'($urandom & 32'h0F0F_0F0F),
                             PRESS_A_TYP ^ 64'($urandom & 32'h0F0F_0F0F),
                             PRESS_B_TYP ^ 64'($urandom & 32'h0F0F_0F0F),
                             64'(PRESS_C_TYP) ^ 64'($urandom_range(255)),
                             HUM_CAL_TYP ^ 64'($urandom & 32'h0F0F_0F0F));
                1: write_all(rand64(), rand64(), rand64(), rand64(), rand64());
                2: write_all(64'(TEMP_CAL_TYP), PRESS_A_TYP, PRESS_B_TYP,
                             64'(PRESS_C_TYP), HUM_CAL_TYP);
                default: write_all(rand64(),
                                   (rand64() & 64'hFFFF_FFFF_FFFF_0000) | 64'd1,
                                   rand64(), rand64(), rand64());
            endcase
            idle_enable = (ph != 3);
            queue_random(85);
            if (ph == 1)
            begin
                // Hold the sender until the pipe is empty
                hold_samples = 1'b1;
                do
                    @(negedge clk);
                while (start || expected_readings.size() > 0);
                hold_samples = 1'b0;
            end
            queue_random(85);
            drain();
        end

        if (expected_readings.size() > 0)
            report_mismatch($sformatf("%0d results never arrived",
                expected_readings.size()));
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/esc_pkg.sv
hw/rtl/esc_div.sv
hw/rtl/env_sensor_compensation.sv
sim/tb_top.sv
